>>> rtl/core/scsa_pkg.sv
package scsa_pkg;

    localparam int POOL_PAGES  = 32;
    localparam int PAGE_BYTES  = 4096;
    localparam int NUM_CLASSES = 10;
    localparam int MAX_SMALL   = 1024;

    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 17;
    localparam int CFG_W      = 6;
    localparam int CLS_W      = 4;
    localparam int SZ_W       = 11;
    localparam int GRAN_BITS  = 3;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = $clog2(POOL_PAGES);
    localparam int PG_FULL_W  = ADDR_W - PAGE_BITS;
    localparam int NUP_W      = $clog2(POOL_PAGES + 1);
    localparam int OFF_W      = PAGE_BITS + 2;
    localparam int LINK_W     = ADDR_W - GRAN_BITS;
    localparam int LINK_DEPTH = (POOL_PAGES * PAGE_BYTES) / 8;
    localparam int CMP_A      = (NUP_W > CFG_W) ? NUP_W : CFG_W;
    localparam int CMP_W      = ((CMP_A > PG_FULL_W) ? CMP_A : PG_FULL_W) + 1;
    localparam int CFG_RESET  = 32;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] slot_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic read_link;
        logic exec_commit;
        logic link_commit;
    } cmd_t;

    typedef struct packed {
        logic need_link;
    } sts_t;

    function automatic logic [SZ_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        logic [SZ_W-1:0] b;
        case (c)
            4'd0:    b = 11'd8;
            4'd1:    b = 11'd16;
            4'd2:    b = 11'd24;
            4'd3:    b = 11'd32;
            4'd4:    b = 11'd48;
            4'd5:    b = 11'd64;
            4'd6:    b = 11'd128;
            4'd7:    b = 11'd256;
            4'd8:    b = 11'd512;
            default: b = 11'd1024;
        endcase
        return b;
    endfunction

    function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] size);
        logic [CLS_W-1:0] c;
        c = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 2; i >= 0; i--)
        begin
            if (size <= SIZE_W'(class_bytes(CLS_W'(i))))
            begin
                c = CLS_W'(i);
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/scsa_ram.sv
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/scsa_ctrl.sv
module scsa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  scsa_pkg::sts_t sts,
    output scsa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LINK} state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.need_link)
                begin
                    cmd.read_link = 1'b1;
                    state_next    = S_LINK;
                end
                else if (out_free)
                begin
                    cmd.exec_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LINK:
            begin
                if (out_free)
                begin
                    cmd.link_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.exec_commit || cmd.link_commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec_commit || cmd.link_commit) |-> (!out_valid_reg || out_ready))
        else $error("result committed over an untaken transaction");

    a_read_then_link: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_link |=> (state_reg == S_LINK && !in_ready))
        else $error("link read not followed by link wait");

    a_link_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> ($past(cmd.read_link) || $past(state_reg == S_LINK)))
        else $error("link wait entered without a link read");

endmodule

>>> rtl/core/scsa_dp.sv
module scsa_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  scsa_pkg::cmd_t                  cmd,
    output scsa_pkg::sts_t                  sts,
    input  scsa_pkg::in_item_t              in_data,
    input  logic                            cfg_we,
    input  logic [scsa_pkg::CFG_W-1:0]      cfg_data,
    output scsa_pkg::out_item_t             out_data
);

    localparam int AW  = scsa_pkg::ADDR_W;
    localparam int CW  = scsa_pkg::CLS_W;
    localparam int NC  = scsa_pkg::NUM_CLASSES;
    localparam int NP  = scsa_pkg::POOL_PAGES;
    localparam int PB  = scsa_pkg::PAGE_BITS;
    localparam int XW  = scsa_pkg::CMP_W;
    localparam int OW  = scsa_pkg::OFF_W;
    localparam int LW  = scsa_pkg::LINK_W;
    localparam int GB  = scsa_pkg::GRAN_BITS;
    localparam int NW  = scsa_pkg::NUP_W;

    scsa_pkg::in_item_t  in_reg;
    scsa_pkg::out_item_t out_data_reg;
    scsa_pkg::out_item_t out_data_next;

    logic [AW-1:0]                 head_reg  [NC];
    logic [AW-1:0]                 head_next [NC];
    logic [AW-1:0]                 fresh_reg  [NC];
    logic [AW-1:0]                 fresh_next [NC];
    logic [CW-1:0]                 tag_reg  [NP];
    logic [CW-1:0]                 tag_next [NP];
    logic [NW-1:0]                 nup_reg;
    logic [NW-1:0]                 nup_next;
    logic [scsa_pkg::CFG_W-1:0]    pages_in_use_reg;

    logic [CW-1:0]                 cls;
    logic [scsa_pkg::SZ_W-1:0]     sz;
    logic                          too_large;
    logic [AW-1:0]                 head_sel;
    logic [AW-1:0]                 fresh_sel;
    logic                          use_fresh;
    logic [XW-1:0]                 limit;
    logic                          exhausted;
    logic [AW-1:0]                 claim_addr;
    logic [AW-1:0]                 grant_base;
    logic [OW-1:0]                 reach;
    logic [AW-1:0]                 fresh_adv;
    logic [AW-1:0]                 fa;
    logic [scsa_pkg::PG_FULL_W-1:0] fpage;
    logic [CW-1:0]                 ftag;
    logic                          free_ok;
    logic                          link_we;
    logic [LW-1:0]                 link_rdata;

    assign cls       = scsa_pkg::size_class(in_reg.request_size);
    assign sz        = scsa_pkg::class_bytes(cls);
    assign too_large = in_reg.request_size > scsa_pkg::SIZE_W'(scsa_pkg::MAX_SMALL);
    assign head_sel  = head_reg[cls];
    assign fresh_sel = fresh_reg[cls];
    assign use_fresh = (fresh_sel != '0);

    assign sts.need_link = (in_reg.opcode == scsa_pkg::OP_ALLOC) && !too_large
                           && (head_sel != '0);

    assign limit = (XW'(pages_in_use_reg) < XW'(NP)) ? XW'(pages_in_use_reg) : XW'(NP);
    assign exhausted = (XW'(nup_reg) >= limit);

    assign claim_addr = AW'({nup_reg[scsa_pkg::PAGE_W-1:0], {PB{1'b0}}}) + AW'(sz);
    assign grant_base = use_fresh ? fresh_sel : claim_addr;
    assign reach      = OW'(grant_base[PB-1:0]) + OW'({sz, 1'b0});
    assign fresh_adv  = (reach > OW'(scsa_pkg::PAGE_BYTES)) ? '0 : grant_base + AW'(sz);

    assign fa      = in_reg.slot_address;
    assign fpage   = fa[AW-1:PB];
    assign ftag    = tag_reg[fpage[scsa_pkg::PAGE_W-1:0]];
    assign free_ok = (fa != '0) && (fa[PB-1:0] != '0) && (XW'(fpage) < XW'(NP))
                     && (XW'(fpage) < XW'(nup_reg)) && (ftag < CW'(NC));

    assign link_we = cmd.exec_commit && (in_reg.opcode == scsa_pkg::OP_FREE) && free_ok;

    scsa_ram #(
        .WIDTH (LW),
        .DEPTH (scsa_pkg::LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (fa[AW-1:GB]),
        .wdata (head_reg[ftag][AW-1:GB]),
        .re    (cmd.read_link),
        .raddr (head_sel[AW-1:GB]),
        .rdata (link_rdata)
    );

    always_comb
    begin
        head_next     = head_reg;
        fresh_next    = fresh_reg;
        tag_next      = tag_reg;
        nup_next      = nup_reg;
        out_data_next = out_data_reg;
        if (cmd.link_commit)
        begin
            head_next[cls]                = {link_rdata, {GB{1'b0}}};
            out_data_next.granted_address = head_sel;
            out_data_next.status          = scsa_pkg::ST_OK;
        end
        else if (cmd.exec_commit)
        begin
            out_data_next.granted_address = '0;
            if (in_reg.opcode == scsa_pkg::OP_FREE)
            begin
                if (free_ok)
                begin
                    head_next[ftag]      = fa;
                    out_data_next.status = scsa_pkg::ST_OK;
                end
                else
                begin
                    out_data_next.status = scsa_pkg::ST_IGNORED;
                end
            end
            else if (too_large)
            begin
                out_data_next.status = scsa_pkg::ST_TOO_LARGE;
            end
            else if (use_fresh)
            begin
                fresh_next[cls]               = fresh_adv;
                out_data_next.granted_address = fresh_sel;
                out_data_next.status          = scsa_pkg::ST_OK;
            end
            else if (exhausted)
            begin
                out_data_next.status = scsa_pkg::ST_EXHAUSTED;
            end
            else
            begin
                tag_next[nup_reg[scsa_pkg::PAGE_W-1:0]] = cls;
                fresh_next[cls]               = fresh_adv;
                nup_next                      = nup_reg + NW'(1);
                out_data_next.granted_address = claim_addr;
                out_data_next.status          = scsa_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                head_reg[i]  <= '0;
                fresh_reg[i] <= AW'(i * scsa_pkg::PAGE_BYTES)
                                + AW'(scsa_pkg::class_bytes(CW'(i)));
            end
            for (int i = 0; i < NP; i++)
            begin
                tag_reg[i] <= (i < NC) ? CW'(i) : '0;
            end
            nup_reg          <= NW'(NC);
            pages_in_use_reg <= scsa_pkg::CFG_W'(scsa_pkg::CFG_RESET);
        end
        else
        begin
            head_reg  <= head_next;
            fresh_reg <= fresh_next;
            tag_reg   <= tag_next;
            nup_reg   <= nup_next;
            if (cfg_we)
            begin
                pages_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

    a_page_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nup_reg >= NW'(NC)) && (XW'(nup_reg) <= XW'(NP)))
        else $error("claimed page count out of range");

    a_pop_grants_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link_commit |=> (out_data_reg.status == scsa_pkg::ST_OK
                             && out_data_reg.granted_address != '0))
        else $error("free list pop produced no slot");

    a_free_grants_none: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec_commit && in_reg.opcode == scsa_pkg::OP_FREE)
        |=> (out_data_reg.granted_address == '0))
        else $error("free produced a granted address");

endmodule

>>> rtl/core/size_class_slab_allocator.sv
// Requests are taken only while idle, one at a time; out_valid is registered, and a commit
// waits while a result is untaken. A free-list pop adds a link state, set by the registered
// read of the single link memory, whose next pointer becomes the new list head.
// Reset: asynchronous, active low. Free lists empty, pages 0 to 9 given to classes 0 to 9,
// pages_in_use at 32. The link memory is not cleared and needs no clearing pass.
module size_class_slab_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  scsa_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output scsa_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scsa_pkg::CFG_W-1:0]    cfg_data
);

    scsa_pkg::cmd_t cmd;
    scsa_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    scsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    scsa_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule
